[src/assert_macros.svh]
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PCXD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PCXD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/pcxd_pkg.sv]
package pcxd_pkg;

   // Frame geometry and header size
   localparam int FRAME_WIDTH  = 320;
   localparam int MAX_HEIGHT   = 200;
   localparam int HEADER_BYTES = 128;

   // Widths, fixed and derived
   localparam int ADDR_W = 16;
   localparam int BYTE_W = 8;
   localparam int RUN_W  = 6;
   localparam int RUN_MAX = (1 << RUN_W) - 1;
   localparam int OFS_W  = $clog2(HEADER_BYTES);
   localparam int COL_W  = $clog2(FRAME_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int CMP_W  = $clog2(FRAME_WIDTH + RUN_MAX + 1);
   localparam int STAT_W = 2;

   // Header layout
   localparam int HDR_ID_BYTES = 4;
   localparam int ID_IDX_W     = $clog2(HDR_ID_BYTES);
   localparam int HDR_XMAX_LO  = 8;
   localparam int HDR_XMAX_HI  = 9;
   localparam int HDR_YMAX_LO  = 10;
   localparam int HDR_YMAX_HI  = 11;

   localparam logic [BYTE_W-1:0] HDR_MANUFACTURER = 8'h0A;
   localparam logic [BYTE_W-1:0] HDR_VERSION      = 8'h05;
   localparam logic [BYTE_W-1:0] HDR_ENCODING     = 8'h01;
   localparam logic [BYTE_W-1:0] HDR_BPP          = 8'h08;

   // Run byte marker: both top bits set
   localparam logic [1:0] RUN_MARK = 2'b11;

   // Status codes
   localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_BAD_HEADER = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_MALFORMED  = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic load_pixel;
      logic load_status;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic acc_has_pixels;
      logic acc_eof;
      logic rem_last;
      logic eof_held;
      logic slot_free;
   } dp_stat_type;

endpackage

[src/pcxd_req_if.sv]
interface pcxd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

[src/pcxd_rsp_if.sv]
interface pcxd_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_status;
   logic [15:0] pixel_address;
   logic [7:0]  pixel_value;
   logic [1:0]  status;
   logic        last_of_run;

   modport source (output valid, output is_status, output pixel_address,
                   output pixel_value, output status, output last_of_run,
                   input ready);
   modport sink   (input valid, input is_status, input pixel_address,
                   input pixel_value, input status, input last_of_run,
                   output ready);
endinterface

[src/pcxd_datapath.sv]
`include "assert_macros.svh"

module pcxd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcxd_pkg::ctrl_cmd_type                cmd,
   output pcxd_pkg::dp_stat_type                 stat,
   input  logic [pcxd_pkg::BYTE_W-1:0]           data_byte,
   input  logic                                  end_of_file,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_is_status,
   output logic [pcxd_pkg::ADDR_W-1:0]           rsp_pixel_address,
   output logic [pcxd_pkg::BYTE_W-1:0]           rsp_pixel_value,
   output logic [pcxd_pkg::STAT_W-1:0]           rsp_status,
   output logic                                  rsp_last_of_run
);
   import pcxd_pkg::*;

   // Decode state
   logic [OFS_W-1:0]                     header_offset_ff, header_offset_in;
   logic                                 header_done_ff, header_done_in;
   logic [HDR_ID_BYTES-1:0][BYTE_W-1:0]  id_bytes_ff, id_bytes_in;
   logic [ADDR_W-1:0]                    right_edge_ff, right_edge_in;
   logic [ADDR_W-1:0]                    row_limit_ff, row_limit_in;
   logic [COL_W-1:0]                     column_ff, column_in;
   logic [ROW_W-1:0]                     row_ff, row_in;
   logic [ADDR_W-1:0]                    row_base_ff, row_base_in;
   logic [RUN_W-1:0]                     pending_ff, pending_in;
   logic                                 awaiting_ff, awaiting_in;
   logic [STAT_W-1:0]                    error_ff, error_in;
   logic                                 finished_ff, finished_in;

   // Current item
   logic [RUN_W-1:0]                     remaining_ff, remaining_in;
   logic [BYTE_W-1:0]                    value_ff, value_in;
   logic                                 eof_ff, eof_in;

   // Output register
   logic                                 out_valid_ff, out_valid_in;
   logic                                 out_is_status_ff, out_is_status_in;
   logic [ADDR_W-1:0]                    out_addr_ff, out_addr_in;
   logic [BYTE_W-1:0]                    out_value_ff, out_value_in;
   logic [STAT_W-1:0]                    out_status_ff, out_status_in;
   logic                                 out_last_ff, out_last_in;

   logic                                 active;
   logic                                 header_ok;
   logic                                 run_check;
   logic [RUN_W-1:0]                     run_len;
   logic                                 run_over;
   logic                                 emit_run;
   logic [COL_W-1:0]                     col_next;
   logic [ROW_W-1:0]                     row_next;
   logic                                 slot_free;
   logic [STAT_W-1:0]                    final_code;

   assign active    = (error_ff == STATUS_OK) && !finished_ff;
   assign slot_free = !out_valid_ff || rsp_ready;

   assign header_ok = (id_bytes_ff[0] == HDR_MANUFACTURER)
                   && (id_bytes_ff[1] == HDR_VERSION)
                   && (id_bytes_ff[2] == HDR_ENCODING)
                   && (id_bytes_ff[3] == HDR_BPP)
                   && (right_edge_ff < ADDR_W'(FRAME_WIDTH))
                   && (row_limit_ff < ADDR_W'(MAX_HEIGHT));

   // Classify an incoming data byte: value byte of a run, run byte, or literal
   always_comb begin
      run_check = 1'b0;
      run_len   = '0;
      if (awaiting_ff) begin
         run_check = 1'b1;
         run_len   = pending_ff;
      end else if (data_byte[BYTE_W-1 -: 2] != RUN_MARK) begin
         run_check = 1'b1;
         run_len   = RUN_W'(1);
      end
   end

   assign run_over = (CMP_W'(column_ff) + CMP_W'(run_len))
                   > (CMP_W'(right_edge_ff) + CMP_W'(2));
   assign emit_run = active && header_done_ff && run_check && !run_over
                   && (run_len != '0);

   assign col_next = column_ff + COL_W'(1);
   assign row_next = row_ff + ROW_W'(1);

   always_comb begin
      if (error_ff != STATUS_OK)  final_code = error_ff;
      else if (!header_done_ff)   final_code = STATUS_BAD_HEADER;
      else if (!finished_ff)      final_code = STATUS_MALFORMED;
      else                        final_code = STATUS_OK;
   end

   always_comb begin
      header_offset_in = header_offset_ff;
      header_done_in   = header_done_ff;
      id_bytes_in      = id_bytes_ff;
      right_edge_in    = right_edge_ff;
      row_limit_in     = row_limit_ff;
      column_in        = column_ff;
      row_in           = row_ff;
      row_base_in      = row_base_ff;
      pending_in       = pending_ff;
      awaiting_in      = awaiting_ff;
      error_in         = error_ff;
      finished_in      = finished_ff;
      remaining_in     = remaining_ff;
      value_in         = value_ff;
      eof_in           = eof_ff;
      out_valid_in     = out_valid_ff && !rsp_ready;
      out_is_status_in = out_is_status_ff;
      out_addr_in      = out_addr_ff;
      out_value_in     = out_value_ff;
      out_status_in    = out_status_ff;
      out_last_in      = out_last_ff;

      if (cmd.accept) begin
         value_in     = data_byte;
         eof_in       = end_of_file;
         remaining_in = '0;
         if (active && !header_done_ff) begin
            if (header_offset_ff < OFS_W'(HDR_ID_BYTES))
               id_bytes_in[header_offset_ff[ID_IDX_W-1:0]] = data_byte;
            if (header_offset_ff == OFS_W'(HDR_XMAX_LO)) right_edge_in[7:0]  = data_byte;
            if (header_offset_ff == OFS_W'(HDR_XMAX_HI)) right_edge_in[15:8] = data_byte;
            if (header_offset_ff == OFS_W'(HDR_YMAX_LO)) row_limit_in[7:0]   = data_byte;
            if (header_offset_ff == OFS_W'(HDR_YMAX_HI)) row_limit_in[15:8]  = data_byte;
            if (header_offset_ff == OFS_W'(HEADER_BYTES - 1)) begin
               header_done_in = 1'b1;
               if (!header_ok)
                  error_in = STATUS_BAD_HEADER;
               else if (row_limit_ff == '0)
                  finished_in = 1'b1;
            end else begin
               header_offset_in = header_offset_ff + OFS_W'(1);
            end
         end else if (active) begin
            if (awaiting_ff) begin
               awaiting_in = 1'b0;
            end else if (!run_check) begin
               pending_in  = data_byte[RUN_W-1:0];
               awaiting_in = 1'b1;
            end
            if (run_check) begin
               if (run_over) error_in = STATUS_MALFORMED;
               else          remaining_in = run_len;
            end
         end
      end

      if (cmd.load_pixel) begin
         out_valid_in     = 1'b1;
         out_is_status_in = 1'b0;
         out_addr_in      = row_base_ff + ADDR_W'(column_ff);
         out_value_in     = value_ff;
         out_status_in    = STATUS_OK;
         out_last_in      = (remaining_ff == RUN_W'(1)) && !eof_ff;
         remaining_in     = remaining_ff - RUN_W'(1);
         column_in        = col_next;
         if ((remaining_ff == RUN_W'(1)) && (ADDR_W'(col_next) > right_edge_ff)) begin
            column_in   = '0;
            row_in      = row_next;
            row_base_in = row_base_ff + ADDR_W'(FRAME_WIDTH);
            if (ADDR_W'(row_next) >= row_limit_ff) finished_in = 1'b1;
         end
      end

      if (cmd.load_status) begin
         out_valid_in     = 1'b1;
         out_is_status_in = 1'b1;
         out_addr_in      = '0;
         out_value_in     = '0;
         out_status_in    = final_code;
         out_last_in      = 1'b1;
         header_offset_in = '0;
         header_done_in   = 1'b0;
         id_bytes_in      = '0;
         right_edge_in    = '0;
         row_limit_in     = '0;
         column_in        = '0;
         row_in           = '0;
         row_base_in      = '0;
         pending_in       = '0;
         awaiting_in      = 1'b0;
         error_in         = STATUS_OK;
         finished_in      = 1'b0;
         eof_in           = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_offset_ff <= '0;
         header_done_ff   <= 1'b0;
         id_bytes_ff      <= '0;
         right_edge_ff    <= '0;
         row_limit_ff     <= '0;
         column_ff        <= '0;
         row_ff           <= '0;
         row_base_ff      <= '0;
         pending_ff       <= '0;
         awaiting_ff      <= 1'b0;
         error_ff         <= STATUS_OK;
         finished_ff      <= 1'b0;
         remaining_ff     <= '0;
         eof_ff           <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         header_offset_ff <= header_offset_in;
         header_done_ff   <= header_done_in;
         id_bytes_ff      <= id_bytes_in;
         right_edge_ff    <= right_edge_in;
         row_limit_ff     <= row_limit_in;
         column_ff        <= column_in;
         row_ff           <= row_in;
         row_base_ff      <= row_base_in;
         pending_ff       <= pending_in;
         awaiting_ff      <= awaiting_in;
         error_ff         <= error_in;
         finished_ff      <= finished_in;
         remaining_ff     <= remaining_in;
         eof_ff           <= eof_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff         <= value_in;
      out_is_status_ff <= out_is_status_in;
      out_addr_ff      <= out_addr_in;
      out_value_ff     <= out_value_in;
      out_status_ff    <= out_status_in;
      out_last_ff      <= out_last_in;
   end

   assign stat.acc_has_pixels = emit_run;
   assign stat.acc_eof        = end_of_file;
   assign stat.rem_last       = (remaining_ff == RUN_W'(1));
   assign stat.eof_held       = eof_ff;
   assign stat.slot_free      = slot_free;

   assign rsp_valid         = out_valid_ff;
   assign rsp_is_status     = out_is_status_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_pixel_value   = out_value_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_last_of_run   = out_last_ff;

   `PCXD_ASSERT_IMPL(a_col_in_frame, clock, reset, 1'b1, column_ff <= COL_W'(FRAME_WIDTH), "column beyond frame width")
   `PCXD_ASSERT_IMPL(a_finish_after_header, clock, reset, finished_ff, header_done_ff, "decode finished without header")
   `PCXD_ASSERT_NEXT(a_status_clears, clock, reset, cmd.load_status, !header_done_ff && !awaiting_ff && (error_ff == STATUS_OK), "state not cleared after status")

endmodule

[src/pcxd_ctrl.sv]
`include "assert_macros.svh"

module pcxd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pcxd_pkg::dp_stat_type  stat,
   output pcxd_pkg::ctrl_cmd_type cmd
);
   import pcxd_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_STATUS} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd.accept      = 1'b0;
      cmd.load_pixel  = 1'b0;
      cmd.load_status = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Hold off the input while reset is applied.
            req_ready  = !reset;
            cmd.accept = req_valid && !reset;
            if (cmd.accept) begin
               if (stat.acc_has_pixels) state_in = ST_EMIT;
               else if (stat.acc_eof)   state_in = ST_STATUS;
            end
         end
         ST_EMIT: begin
            if (stat.slot_free) begin
               cmd.load_pixel = 1'b1;
               if (stat.rem_last) state_in = stat.eof_held ? ST_STATUS : ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (stat.slot_free) begin
               cmd.load_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   `PCXD_ASSERT_NEXT(a_run_enters_emit, clock, reset, cmd.accept && stat.acc_has_pixels, state_ff == ST_EMIT, "run did not start emitting")
   `PCXD_ASSERT_NEXT(a_status_to_idle, clock, reset, cmd.load_status, state_ff == ST_IDLE, "no return to idle after status")

endmodule

[src/pcx_rle_image_decoder.sv]
// Output: a byte with pixels moves the sequencer to its emit state, which loads the output
// register with one pixel item per cycle while rsp is not stalled, then the status item if
//   the byte closed the file. Header and run-count bytes keep it idle, the one state taking bytes.
// A stalled rsp holds the emit loop; the output register lets one item wait while work goes on.
// Reset: synchronous, active high; clears all decode state; the status item also clears it.
module pcx_rle_image_decoder (
   input  logic       clock,
   input  logic       reset,
   pcxd_req_if.sink   req_chan,
   pcxd_rsp_if.source rsp_chan
);
   import pcxd_pkg::*;

   // Command and status groups between the sequencer and the datapath
   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // Sequencer: take a byte when idle, then drive one pixel item per free output
   // slot, and the status item last when the byte closed the file.
   pcxd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: header capture and check, run classification, row and column
   // tracking with an added row base instead of a multiply, and the output register.
   pcxd_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .data_byte         (req_chan.data_byte),
      .end_of_file       (req_chan.end_of_file),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_is_status     (rsp_chan.is_status),
      .rsp_pixel_address (rsp_chan.pixel_address),
      .rsp_pixel_value   (rsp_chan.pixel_value),
      .rsp_status        (rsp_chan.status),
      .rsp_last_of_run   (rsp_chan.last_of_run)
   );

endmodule
